[hdl/pva_pkg.sv]
// Package for the polyphonic voice allocator: constants, codes and entry type.
// No dependencies.
package pva_pkg;

	localparam int MaxVoicesDef = 16;
	localparam int CountW = 5;
	localparam logic [7:0] NoNote = 8'hFF;

	localparam logic [1:0] KIND_ON = 2'd0;
	localparam logic [1:0] KIND_OFF = 2'd1;
	localparam logic [1:0] KIND_UPD = 2'd2;
	localparam logic [1:0] KIND_CLEAN = 2'd3;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ATTACK = 3'd1;
	localparam logic [2:0] PH_RELEASE = 3'd4;

	localparam logic [3:0] OC_IDLE_TAKEN = 4'd0;
	localparam logic [3:0] OC_REL_STOLEN = 4'd1;
	localparam logic [3:0] OC_ACT_STOLEN = 4'd2;
	localparam logic [3:0] OC_FALLBACK = 4'd3;
	localparam logic [3:0] OC_RELEASED = 4'd4;
	localparam logic [3:0] OC_DUP_OFF = 4'd5;
	localparam logic [3:0] OC_LATE_OFF = 4'd6;
	localparam logic [3:0] OC_NOT_FOUND = 4'd7;
	localparam logic [3:0] OC_UPDATE = 4'd8;
	localparam logic [3:0] OC_CLEANUP = 4'd9;

	// note, phase, level, order
	localparam int EntryW = 8 + 3 + 16 + 32;

	typedef struct packed {
		logic [7:0] note;
		logic [2:0] phase;
		logic [15:0] level;
		logic [31:0] order;
	} entry_t;

endpackage

[hdl/pva_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pva_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/polyphonic_voice_allocator.sv]
// Polyphonic voice allocator: voice table in one RAM, scanned by a sequencer.
// Depends on pva_pkg and pva_ram.
//
// After reset the block clears the MAX_VOICES entries of the voice table, one
// entry a cycle, before it takes the first item. Each item scans the live
// voices through the single RAM read port, one entry a cycle: a note-on takes
// up to three passes, a note-off up to three, cleanup one, an update none.
// The block returns to idle after each item before it takes the next one.
// One item is worked at a time; the result is held in an output register while
// the next item is taken, and a finished item waits only while that register
// still holds an unaccepted result.
module polyphonic_voice_allocator
	import pva_pkg::*;
#(
	parameter int MAX_VOICES = MaxVoicesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [6:0]  note,
	input  logic [31:0] note_seq,
	input  logic [3:0]  voice,
	input  logic [2:0]  env_phase,
	input  logic [15:0] env_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  chosen_voice,
	output logic [3:0]  outcome
);
	localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int RD = 1 << AW;
	localparam int CW = AW + 1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_LAST  = 7'b0001000,
		ST_WRITE = 7'b0010000,
		ST_PASS  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [4:0]  cnt_cfg_q;
	logic [1:0]  kind_q;
	logic [6:0]  note_q;
	logic [31:0] order_q;
	logic [3:0]  vsel_q;
	logic [2:0]  ph_q;
	logic [15:0] lvl_q;
	logic [1:0]  pass_q;
	logic [AW-1:0] rd_idx_q;
	logic        rd_act_q;
	logic [AW-1:0] idx_s1;
	logic        vld_s1;
	logic        found_q;
	logic [AW-1:0] pick_q;
	logic [32:0] best_q;
	entry_t      pick_e_q;
	logic        out_valid_q;
	logic [3:0]  ov_q, oo_q;
	logic [3:0]  oc_q;
	logic [3:0]  cv_q;
	logic [CW-1:0] n_live;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wdata, rdata;

	pva_ram #(.Width(EntryW), .Depth(RD)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		n_live = CW'(cnt_cfg_q);
		if (cnt_cfg_q == 5'd0) n_live = CW'(1);
		if ({27'd0, cnt_cfg_q} > 32'(MAX_VOICES)) n_live = CW'(MAX_VOICES);
	end

	logic act, match, cand;
	logic last_rd;
	assign act = rdata.phase != PH_IDLE && rdata.phase != PH_RELEASE;
	assign match = rdata.note == {1'b0, note_q};
	assign last_rd = {1'b0, rd_idx_q} == n_live - CW'(1);

	always_comb begin
		cand = 1'b0;
		if (kind_q == KIND_ON) begin
			case (pass_q)
				2'd0: cand = !found_q && rdata.phase == PH_IDLE;
				2'd1: cand = rdata.phase == PH_RELEASE && {17'd0, rdata.level} < best_q;
				default: cand = act && {1'b0, rdata.order} < best_q;
			endcase
		end else if (kind_q == KIND_OFF) begin
			case (pass_q)
				2'd0: cand = match && act && {1'b0, rdata.order} < best_q;
				2'd1: cand = !found_q && match && rdata.phase == PH_RELEASE;
				default: cand = !found_q && match && rdata.phase == PH_IDLE;
			endcase
		end
	end

	logic clean_hit;
	assign clean_hit = rdata.phase == PH_IDLE && rdata.note != NoNote && rdata.note != 8'd0;

	logic [32:0] best_init;
	always_comb begin
		best_init = 33'h1_FFFF_FFFF;
		if (kind_q == KIND_ON && pass_q == 2'd1) best_init = 33'h1_0000;
		if (kind_q == KIND_ON && pass_q == 2'd2) best_init = {1'b0, order_q} + 33'd1;
	end

	always_comb begin
		we = 1'b0;
		waddr = pick_q;
		wdata = pick_e_q;
		raddr = rd_idx_q;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = rd_idx_q;
			wdata = '{note: NoNote, phase: PH_IDLE, level: 16'd0, order: 32'd0};
		end else if (state_q == ST_SCAN && kind_q == KIND_CLEAN && vld_s1 && clean_hit) begin
			we = 1'b1;
			waddr = idx_s1;
			wdata = rdata;
			wdata.note = NoNote;
		end else if (state_q == ST_WRITE) begin
			we = kind_q != KIND_OFF || found_q;
			if (kind_q == KIND_UPD) begin
				waddr = AW'(vsel_q);
				wdata = rdata;
				wdata.phase = ph_q;
				wdata.level = lvl_q;
				we = {28'd0, vsel_q} < 32'(MAX_VOICES);
			end else if (kind_q == KIND_ON) begin
				if (oc_q == OC_FALLBACK) wdata = rdata;
				wdata.note = {1'b0, note_q};
				wdata.order = order_q;
				wdata.phase = PH_ATTACK;
			end else begin
				wdata.note = NoNote;
				if (oc_q == OC_RELEASED) wdata.phase = PH_RELEASE;
			end
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign chosen_voice = ov_q;
	assign outcome = oo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_cfg_q <= 5'd16;
			rd_idx_q <= '0;
			rd_act_q <= 1'b0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			pass_q <= 2'd0;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) cnt_cfg_q <= cfg_wdata;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			vld_s1 <= state_q == ST_SCAN && rd_act_q;
			idx_s1 <= rd_idx_q;
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(rd_idx_q) == MAX_VOICES - 1) begin
						rd_idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= kind; note_q <= note; order_q <= note_seq;
						vsel_q <= voice; ph_q <= env_phase; lvl_q <= env_level;
						pass_q <= 2'd0;
						found_q <= 1'b0;
						pick_q <= '0;
						best_q <= 33'h1_FFFF_FFFF;
						if (kind == KIND_UPD) begin
							rd_idx_q <= AW'(voice);
							state_q <= ST_LAST;
						end else begin
							rd_idx_q <= '0;
							rd_act_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1) begin
						if (cand) begin
							found_q <= 1'b1;
							pick_q <= idx_s1;
							pick_e_q <= rdata;
							if (pass_q == 2'd1) best_q <= {17'd0, rdata.level};
							else best_q <= {1'b0, rdata.order};
						end
						if ({1'b0, idx_s1} == n_live - CW'(1)) begin
							state_q <= ST_PASS;
						end
					end
					if (rd_act_q) begin
						if (last_rd) rd_act_q <= 1'b0;
						else rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_LAST: state_q <= ST_WRITE;
				ST_PASS: begin
					rd_idx_q <= '0;
					if (kind_q == KIND_CLEAN) begin
						oc_q <= OC_CLEANUP; cv_q <= '0; state_q <= ST_DONE;
					end else if (kind_q == KIND_ON) begin
						if (found_q) begin
							state_q <= ST_WRITE;
							oc_q <= 4'(pass_q);
						end else if (pass_q == 2'd2) begin
							oc_q <= OC_FALLBACK;
							pick_q <= '0;
							state_q <= ST_LAST;
						end else begin
							pass_q <= pass_q + 2'd1;
							state_q <= ST_SCAN; rd_act_q <= 1'b1;
							best_q <= (pass_q == 2'd0) ? 33'h1_0000 : {1'b0, order_q} + 33'd1;
						end
					end else begin
						if (found_q || pass_q == 2'd2) begin
							state_q <= ST_WRITE;
							oc_q <= found_q ? (OC_RELEASED + 4'(pass_q)) : OC_NOT_FOUND;
						end else begin
							pass_q <= pass_q + 2'd1;
							state_q <= ST_SCAN; rd_act_q <= 1'b1;
							best_q <= best_init;
						end
					end
				end
				ST_WRITE: begin
					if (kind_q == KIND_ON) begin
						cv_q <= 4'(pick_q);
					end else if (kind_q == KIND_UPD) begin
						oc_q <= OC_UPDATE; cv_q <= '0;
					end else begin
						cv_q <= found_q ? 4'(pick_q) : 4'd0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						oo_q <= oc_q;
						ov_q <= cv_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hdl/pva_checker.sv]
// Port-level checker for the polyphonic voice allocator, bound to the top level.
// Depends on pva_pkg.
module pva_checker
	import pva_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] chosen_voice,
	input logic [3:0] outcome
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(chosen_voice))
		else $error("result changed while stalled");
	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outcome <= OC_CLEANUP)
		else $error("outcome code out of range");
	a_zero_voice: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OC_UPDATE || outcome == OC_CLEANUP ||
		outcome == OC_NOT_FOUND || outcome == OC_FALLBACK) |-> chosen_voice == 4'd0)
		else $error("nonzero voice for a voiceless outcome");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in progress");
endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.chosen_voice(chosen_voice), .outcome(outcome)
);
